FILE: design/i2cbm_pkg.sv
package i2cbm_pkg;

	localparam int unsigned SampleWidth = 8;
	localparam int unsigned PinIdxWidth = $clog2(SampleWidth);
	localparam int unsigned ByteBits    = 8;
	localparam int unsigned CountWidth  = $clog2(ByteBits + 1);
	localparam int unsigned CfgIdxWidth = 2;
	localparam int unsigned CfgDatWidth = 8;

	// register map of the configuration port
	localparam logic [CfgIdxWidth-1:0] REG_CLOCK_PIN = 2'd0;
	localparam logic [CfgIdxWidth-1:0] REG_DATA_PIN  = 2'd1;

	localparam logic [PinIdxWidth-1:0] CLOCK_PIN_RST = 3'd0;
	localparam logic [PinIdxWidth-1:0] DATA_PIN_RST  = 3'd1;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_START = 3'd1,
		EV_ZERO  = 3'd2,
		EV_ONE   = 3'd3,
		EV_ACK   = 3'd4,
		EV_NACK  = 3'd5,
		EV_STOP  = 3'd6
	} bus_event_t;

	typedef struct packed {
		logic [PinIdxWidth-1:0] clock_idx;
		logic [PinIdxWidth-1:0] data_idx;
	} pin_cfg_t;

	typedef struct packed {
		bus_event_t          ev;
		logic [ByteBits-1:0] byte_val;
		logic                is_addr;
	} result_t;

endpackage

FILE: design/i2cbm_cfg.sv
module i2cbm_cfg import i2cbm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgDatWidth-1:0] cfg_data,
	output pin_cfg_t               pin_cfg
);

	pin_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign pin_cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_idx <= CLOCK_PIN_RST;
			cfg_q.data_idx  <= DATA_PIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLOCK_PIN: cfg_q.clock_idx <= cfg_data[PinIdxWidth-1:0];
				REG_DATA_PIN:  cfg_q.data_idx  <= cfg_data[PinIdxWidth-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

endmodule

FILE: design/i2cbm_core.sv
module i2cbm_core import i2cbm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pin_cfg_t               pin_cfg,
	input  logic [SampleWidth-1:0] sample,
	input  logic                   advance,
	output result_t                result
);

	localparam logic [CountWidth-1:0] FullCount = CountWidth'(ByteBits);

	logic                  prev_clk_q;
	logic                  prev_sda_q;
	logic [CountWidth-1:0] bits_q;
	logic [ByteBits-1:0]   shift_q;
	logic                  addr_q;

	logic                  scl;
	logic                  sda;
	logic                  clk_rise;
	logic                  clk_high;
	logic                  sda_fall;
	logic                  sda_rise;
	logic [CountWidth-1:0] bits_dec;
	logic [CountWidth-1:0] bits_d;
	logic [ByteBits-1:0]   shift_d;
	logic                  addr_d;

	assign scl      = sample[pin_cfg.clock_idx];
	assign sda      = sample[pin_cfg.data_idx];
	assign clk_rise = !prev_clk_q && scl;
	assign clk_high = prev_clk_q && scl;
	assign sda_fall = prev_sda_q && !sda;
	assign sda_rise = !prev_sda_q && sda;
	assign bits_dec = bits_q - 1'b1;

	always_comb begin
		bits_d          = bits_q;
		shift_d         = shift_q;
		addr_d          = addr_q;
		result.ev       = EV_NONE;
		result.byte_val = '0;
		result.is_addr  = 1'b0;

		if (sda_fall && clk_high) begin
			shift_d   = '0;
			bits_d    = FullCount;
			addr_d    = 1'b1;
			result.ev = EV_START;
		end

		// data only counts when it held steady over the clock rise
		if (clk_rise && (sda == prev_sda_q)) begin
			if (bits_q != '0 && bits_q <= FullCount) begin
				bits_d = bits_dec;
				if (sda) begin
					shift_d[bits_dec[PinIdxWidth-1:0]] = 1'b1;
					result.ev = EV_ONE;
				end else begin
					result.ev = EV_ZERO;
				end
			end else begin
				result.byte_val = shift_q;
				result.is_addr  = addr_q;
				if (sda) begin
					result.ev = EV_NACK;
				end else begin
					result.ev = EV_ACK;
					shift_d   = '0;
					bits_d    = FullCount;
					addr_d    = 1'b0;
				end
			end
		end

		if (sda_rise && clk_high) begin
			result.ev = EV_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clk_q <= 1'b1;
			prev_sda_q <= 1'b1;
			bits_q     <= '0;
			shift_q    <= '0;
			addr_q     <= 1'b0;
		end else if (advance) begin
			prev_clk_q <= scl;
			prev_sda_q <= sda;
			bits_q     <= bits_d;
			shift_q    <= shift_d;
			addr_q     <= addr_d;
		end
	end

	// bit counter stays within a byte
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= FullCount)
		else $error("bit counter out of range");

	// a start always arms a fresh address byte
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.ev == EV_START |=> bits_q == FullCount && addr_q && shift_q == '0)
		else $error("start did not arm address byte");

	// an ack re-arms collection of a data byte
	a_ack_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.ev == EV_ACK |=> bits_q == FullCount && !addr_q)
		else $error("ack did not re-arm collection");

endmodule

FILE: design/i2c_bus_monitor.sv
// path: an accepted sample is held in the stage 1 input register, classified, and its event
// is registered in the stage 2 result register, which drives the outputs
// throughput: one sample per cycle while out_stall is not holding a result; the bus state loop
// (previous line levels, bit counter, shift byte) feeds back through the classify logic
// reset: asynchronous, active low; lines read as high, no byte being collected,
// clock pin index 0, data pin index 1; both pipeline stages empty
module i2c_bus_monitor import i2cbm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SampleWidth-1:0] pin_sample,
	// event output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             event_code,
	output logic [ByteBits-1:0]    byte_value,
	output logic                   is_address,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CfgDatWidth-1:0] cfg_data
);

	pin_cfg_t pin_cfg;

	// stage 1: input register holding one accepted sample
	logic                   valid_s1;
	logic [SampleWidth-1:0] sample_s1;

	// stage 2: result register feeding the output channel
	logic    valid_s2;
	result_t result_s2;

	logic    s2_free;
	logic    advance;
	logic    in_accept;
	result_t result;

	// the result register can take a new event when empty or being drained this cycle
	assign s2_free   = !valid_s2 || !out_stall;
	// the bus state advances exactly when a sample moves into the result register
	assign advance   = valid_s1 && s2_free;
	// hold off the source only when a sample is parked and the result is blocked
	assign in_stall  = valid_s1 && !s2_free;
	assign in_accept = in_valid && !in_stall;

	i2cbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pin_cfg   (pin_cfg)
	);

	i2cbm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.pin_cfg (pin_cfg),
		.sample  (sample_s1),
		.advance (advance),
		.result  (result)
	);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_s1 <= pin_sample;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = result_s2.ev;
	assign byte_value = result_s2.byte_val;
	assign is_address = result_s2.is_addr;

	// the source is only held off while a sample is parked in stage 1
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input stage");

	// address flag only travels with an ack or nack
	a_addr_with_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_address |-> event_code == EV_ACK || event_code == EV_NACK)
		else $error("address flag on non-ack event");

	// a collected byte is only reported in an ack or nack slot
	a_byte_with_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_value != '0 |-> event_code == EV_ACK || event_code == EV_NACK)
		else $error("byte value on non-ack event");

	// a result leaves the output register only when taken
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule
